>>> src/ascii_unsigned_int_parser_assert.svh
// Assertion macros shared by the ASCII unsigned integer parser RTL.
// Needs nothing else; each macro expands to one labeled concurrent assertion.
`ifndef ASCII_UNSIGNED_INT_PARSER_ASSERT_SVH
`define ASCII_UNSIGNED_INT_PARSER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AUIP_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed in ascii_unsigned_int_parser");

// The consequent must hold in the cycle after the antecedent.
`define AUIP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed in ascii_unsigned_int_parser");

`endif

>>> src/auip_pkg.sv
// Package for the ASCII unsigned integer parser: beat types, character codes,
// register indexes and parse state types. Depends on nothing.
package auip_pkg;

   localparam int AUIP_ACC_BITS_DEFAULT = 64;

   localparam logic [7:0] CHAR_SEP   = 8'h27;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_UA    = 8'h41;
   localparam logic [7:0] CHAR_UF    = 8'h46;
   localparam logic [7:0] CHAR_LX    = 8'h78;

   localparam logic [3:0] HEX_LETTER_OFFSET = 4'd9;

   typedef enum logic {
      CSR_HEX_MODE     = 1'b0,
      CSR_WIDTH_SELECT = 1'b1
   } auip_csr_index_type;

   typedef enum logic [1:0] {
      WIDTH_8  = 2'd0,
      WIDTH_16 = 2'd1,
      WIDTH_32 = 2'd2,
      WIDTH_64 = 2'd3
   } auip_width_type;

   typedef enum logic [1:0] {
      PFX_EXPECT_ZERO = 2'd0,
      PFX_EXPECT_X    = 2'd1,
      PFX_DONE        = 2'd2
   } auip_prefix_type;

   typedef struct packed {
      logic [7:0] char_code;
      logic       last_char;
   } auip_req_type;

   typedef struct packed {
      logic        parse_ok;
      logic [63:0] parsed_value;
   } auip_rsp_type;

   // Per-string parse flags carried between the top level and the step logic.
   typedef struct packed {
      logic            prev_sep;
      logic            failed;
      auip_prefix_type prefix_pos;
   } auip_flags_type;

endpackage

>>> src/auip_char_step.sv
// Next parse state for one character: prefix check, digit decode, separator
// rules and the shift-add multiply with exact overflow check. Uses auip_pkg.
module auip_char_step import auip_pkg::*; #(
   parameter int ACC_BITS = AUIP_ACC_BITS_DEFAULT
) (
   input  logic [7:0]          char_code,
   input  logic                hex_mode,
   input  auip_width_type      width_select,
   input  logic [ACC_BITS-1:0] acc_cur,
   input  auip_flags_type      flags_cur,
   output logic [ACC_BITS-1:0] acc_next,
   output auip_flags_type      flags_next
);

   localparam int ProdBits = ACC_BITS + 4;

   logic                is_dec;
   logic                is_hex_letter;
   logic                is_digit;
   logic [3:0]          digit;
   logic [ACC_BITS-1:0] limit_mask;
   logic [ProdBits-1:0] acc_ext;
   logic [ProdBits-1:0] product;
   logic                overflow;
   logic                in_prefix;

   assign is_dec        = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
   assign is_hex_letter = hex_mode && (char_code >= CHAR_UA) && (char_code <= CHAR_UF);
   assign is_digit      = is_dec || is_hex_letter;
   assign digit         = is_dec ? char_code[3:0] : 4'(char_code[3:0] + HEX_LETTER_OFFSET);
   assign in_prefix     = hex_mode && ((flags_cur.prefix_pos == PFX_EXPECT_ZERO) ||
                                       (flags_cur.prefix_pos == PFX_EXPECT_X));

   // Largest value allowed at the selected width, capped at the accumulator width.
   always_comb begin
      for (int i = 0; i < ACC_BITS; i++) begin
         limit_mask[i] = (i < (8 << width_select));
      end
   end

   // acc * base + digit by shifts and adds, wide enough that nothing is lost.
   always_comb begin
      acc_ext = {4'b0000, acc_cur};
      if (hex_mode) begin
         product = (acc_ext << 4) + ProdBits'(digit);
      end else begin
         product = (acc_ext << 3) + (acc_ext << 1) + ProdBits'(digit);
      end
      overflow = product > {4'b0000, limit_mask};
   end

   always_comb begin
      acc_next   = acc_cur;
      flags_next = flags_cur;
      if (!flags_cur.failed) begin
         if (in_prefix) begin
            if ((flags_cur.prefix_pos == PFX_EXPECT_ZERO) && (char_code == CHAR_ZERO)) begin
               flags_next.prefix_pos = PFX_EXPECT_X;
            end else if ((flags_cur.prefix_pos == PFX_EXPECT_X) &&
                         (char_code == CHAR_LX)) begin
               flags_next.prefix_pos = PFX_DONE;
            end else begin
               flags_next.failed = 1'b1;
            end
         end else if (!is_digit) begin
            if ((char_code == CHAR_SEP) && !flags_cur.prev_sep) begin
               flags_next.prev_sep = 1'b1;
            end else begin
               flags_next.failed = 1'b1;
            end
         end else begin
            flags_next.prev_sep = 1'b0;
            if (overflow) begin
               flags_next.failed = 1'b1;
            end else begin
               acc_next = product[ACC_BITS-1:0];
            end
         end
      end
   end

endmodule

>>> src/ascii_unsigned_int_parser.sv
// ASCII unsigned integer parser, top level. A last character's beat passes
// the input register and then the result register before its result appears.
// One character per cycle is taken, except while a last character waits on a
// stalled result side. Synchronous active-high reset clears the parse state,
// both handshakes and the CSR registers (hex_mode 0, width_select 64 bits).
`include "ascii_unsigned_int_parser_assert.svh"

module ascii_unsigned_int_parser import auip_pkg::*; #(
   parameter int ACC_BITS = AUIP_ACC_BITS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  auip_req_type       req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output auip_rsp_type       rsp_data,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  auip_csr_index_type csr_index,
   input  logic [1:0]         csr_data
);

   logic                hex_mode_ff;
   auip_width_type      width_select_ff;

   logic                s1_valid_ff;
   logic                s1_valid_in;
   auip_req_type        s1_req_ff;

   logic [ACC_BITS-1:0] acc_ff;
   logic [ACC_BITS-1:0] acc_in;
   auip_flags_type      flags_ff;
   auip_flags_type      flags_in;

   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   auip_rsp_type        rsp_ff;

   logic [ACC_BITS-1:0] acc_step;
   auip_flags_type      flags_step;
   logic                req_accept;
   logic                out_free;
   logic                s1_advance;
   logic                s1_result;
   logic                string_ok;

   localparam auip_flags_type FlagsClear = '{prev_sep: 1'b1, failed: 1'b0,
                                             prefix_pos: PFX_EXPECT_ZERO};

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         hex_mode_ff     <= 1'b0;
         width_select_ff <= WIDTH_64;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_HEX_MODE:     hex_mode_ff     <= csr_data[0];
            CSR_WIDTH_SELECT: width_select_ff <= auip_width_type'(csr_data);
            default:          ;
         endcase
      end
   end

   auip_char_step #(
      .ACC_BITS(ACC_BITS)
   ) u_step (
      .char_code    (s1_req_ff.char_code),
      .hex_mode     (hex_mode_ff),
      .width_select (width_select_ff),
      .acc_cur      (acc_ff),
      .flags_cur    (flags_ff),
      .acc_next     (acc_step),
      .flags_next   (flags_step)
   );

   // A character that ends no string never waits on the result side.
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign s1_advance = s1_valid_ff && (!s1_req_ff.last_char || out_free);
   assign s1_result  = s1_advance && s1_req_ff.last_char;
   assign req_stall  = s1_valid_ff && !s1_advance;
   assign req_accept = req_valid && !req_stall;

   assign string_ok = !flags_step.failed && !flags_step.prev_sep &&
                      !(hex_mode_ff && (flags_step.prefix_pos != PFX_DONE));

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end

      acc_in   = acc_ff;
      flags_in = flags_ff;
      if (s1_result) begin
         acc_in   = '0;
         flags_in = FlagsClear;
      end else if (s1_advance) begin
         acc_in   = acc_step;
         flags_in = flags_step;
      end

      rsp_valid_in = rsp_valid_ff;
      if (s1_result) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         acc_ff       <= '0;
         flags_ff     <= FlagsClear;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         acc_ff       <= acc_in;
         flags_ff     <= flags_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_req_ff <= req_data;
      end
      if (s1_result) begin
         rsp_ff.parse_ok     <= string_ok;
         rsp_ff.parsed_value <= string_ok ? 64'(acc_step) : 64'd0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `AUIP_ASSERT_SAME(a_fail_value_zero, clock, reset,
      rsp_valid && !rsp_data.parse_ok, rsp_data.parsed_value == 64'd0)
   `AUIP_ASSERT_NEXT(a_clear_after_last, clock, reset,
      s1_result, (acc_ff == '0) && (flags_ff == FlagsClear))
   `AUIP_ASSERT_SAME(a_stall_only_when_held, clock, reset,
      req_stall, s1_valid_ff && s1_req_ff.last_char && rsp_valid_ff)

endmodule
